/* sv/text_console_writer_macros.svh */
// Assertion macros shared by the text console writer RTL.
`ifndef TEXT_CONSOLE_WRITER_MACROS_SVH
`define TEXT_CONSOLE_WRITER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TCW_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("text console writer check failed");

// The consequent must hold in the cycle after the antecedent.
`define TCW_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("text console writer check failed");

`endif

/* sv/tcw_pkg.sv */
// Package with the screen geometry, codes and types of the text console writer.
`timescale 1ns / 1ps

package tcw_pkg;

   // Screen geometry.
   localparam int COLUMNS = 80;
   localparam int ROWS    = 25;
   localparam int CELLS   = COLUMNS * ROWS;

   // Widths: cell address, address plus one bit, column counter, port widths.
   localparam int ADDR_W  = $clog2(CELLS);
   localparam int SPAN_W  = ADDR_W + 1;
   localparam int COL_W   = $clog2(COLUMNS);
   localparam int LOC_W   = 11;
   localparam int BYTE_W  = 8;
   localparam int CELL_W  = 2 * BYTE_W;
   localparam int WIDE_W  = (SPAN_W > LOC_W) ? SPAN_W : LOC_W;

   // Address constants.
   localparam logic [ADDR_W-1:0] COLS_A     = ADDR_W'(COLUMNS);
   localparam logic [ADDR_W-1:0] LAST_A     = ADDR_W'(CELLS - 1);
   localparam logic [ADDR_W-1:0] LAST_ROW_A = ADDR_W'(CELLS - COLUMNS);
   localparam logic [SPAN_W-1:0] CELLS_S    = SPAN_W'(CELLS);
   localparam logic [WIDE_W-1:0] CELLS_W    = WIDE_W'(CELLS);
   localparam logic [COL_W-1:0]  LAST_COL   = COL_W'(COLUMNS - 1);

   // Character and color codes.
   localparam logic [BYTE_W-1:0] NEWLINE_CODE = 8'h0A;
   localparam logic [BYTE_W-1:0] NULL_CODE    = 8'h00;
   localparam logic [BYTE_W-1:0] BLANK_CODE   = 8'h20;
   localparam logic [BYTE_W-1:0] FILL_RESET   = 8'h0A;

   // Request modes.
   localparam logic [1:0] MODE_PUT         = 2'd0;
   localparam logic [1:0] MODE_CLEAR_SCREEN = 2'd1;
   localparam logic [1:0] MODE_CLEAR_LINE  = 2'd2;
   localparam logic [1:0] MODE_READ        = 2'd3;

   // One screen cell: attribute in the high byte, character in the low byte.
   typedef struct packed {
      logic [BYTE_W-1:0] color;
      logic [BYTE_W-1:0] code;
   } cell_type;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_SCROLL,
      ST_DRAIN,
      ST_BLANK
   } state_type;

endpackage

/* sv/tcw_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
`timescale 1ns / 1ps

module tcw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/text_console_writer.sv */
// Top level of the character-cell text console writer with scrolling.
//
//   channel   direction  handshake           payload
//   request   in         start / busy        req_mode, req_char_code, req_char_color,
//                                            req_cell_index
//   response  out        rsp_valid strobe    rsp_cursor_location, rsp_read_char,
//                                            rsp_read_color
//   csr       in         csr_wr_en           csr_wr_data (fill color)
//
// A put, newline, null or out-of-range read answers in the cycle after the request beat,
// unless the put scrolls. An in-range read answers through the registered memory read.
// A scroll moves every row up by one and then blanks the bottom row, a screen clear
// blanks every cell and a line clear blanks the cursor row, one cell at a time through the
// single memory write port. After reset a clearing pass over the whole memory holds busy
// high. The response strobe lasts one cycle and cannot be stalled.
`timescale 1ns / 1ps
`include "text_console_writer_macros.svh"

module text_console_writer (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic [1:0]                 req_mode,
   input  logic [7:0]                 req_char_code,
   input  logic [7:0]                 req_char_color,
   input  logic [10:0]                req_cell_index,
   output logic                       rsp_valid,
   output logic [10:0]                rsp_cursor_location,
   output logic [7:0]                 rsp_read_char,
   output logic [7:0]                 rsp_read_color,
   input  logic                       csr_wr_en,
   input  logic [7:0]                 csr_wr_data
);

   tcw_pkg::state_type state_ff, state_in;

   logic [7:0]                fill_color_ff;
   logic [tcw_pkg::ADDR_W-1:0] base_ff, base_in;
   logic [tcw_pkg::COL_W-1:0]  col_ff, col_in;
   logic [tcw_pkg::ADDR_W-1:0] ptr_ff, ptr_in;
   logic [tcw_pkg::ADDR_W-1:0] end_ff, end_in;
   logic [tcw_pkg::ADDR_W-1:0] wr_addr_ff, wr_addr_in;
   logic                       pend_ff, pend_in;
   logic [7:0]                 blank_color_ff, blank_color_in;
   logic                       rsp_en_ff, rsp_en_in;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic [10:0]                rsp_loc_ff, rsp_loc_in;
   logic [7:0]                 rsp_char_ff, rsp_char_in;
   logic [7:0]                 rsp_color_ff, rsp_color_in;

   logic                       ram_we;
   logic [tcw_pkg::ADDR_W-1:0] ram_waddr;
   tcw_pkg::cell_type          ram_wdata;
   logic [tcw_pkg::ADDR_W-1:0] ram_raddr;
   tcw_pkg::cell_type          ram_rdata;

   logic                       accept;
   logic [tcw_pkg::ADDR_W-1:0] cursor_addr;
   logic [tcw_pkg::SPAN_W-1:0] base_adv;
   logic                       advance_row;
   logic [tcw_pkg::WIDE_W-1:0] idx_wide;
   logic [tcw_pkg::WIDE_W-1:0] loc_wide;

   // Cell memory: the whole screen lives here.
   tcw_ram #(
      .WIDTH(tcw_pkg::CELL_W),
      .DEPTH(tcw_pkg::CELLS)
   ) u_cells (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign accept      = start && (state_ff == tcw_pkg::ST_IDLE);
   assign cursor_addr = base_ff + tcw_pkg::ADDR_W'(col_ff);
   assign base_adv    = tcw_pkg::SPAN_W'(base_ff) + tcw_pkg::SPAN_W'(tcw_pkg::COLS_A);
   assign idx_wide    = tcw_pkg::WIDE_W'(req_cell_index);
   assign loc_wide    = tcw_pkg::WIDE_W'(base_in) + tcw_pkg::WIDE_W'(col_in);

   // Sequencer: next state, memory access and response.
   always_comb begin
      state_in       = state_ff;
      base_in        = base_ff;
      col_in         = col_ff;
      ptr_in         = ptr_ff;
      end_in         = end_ff;
      wr_addr_in     = wr_addr_ff;
      pend_in        = pend_ff;
      blank_color_in = blank_color_ff;
      rsp_en_in      = rsp_en_ff;
      rsp_valid_in   = 1'b0;
      rsp_char_in    = 8'h00;
      rsp_color_in   = 8'h00;
      ram_we         = 1'b0;
      ram_waddr      = ptr_ff;
      ram_wdata      = '{color: blank_color_ff, code: tcw_pkg::BLANK_CODE};
      ram_raddr      = ptr_ff;
      advance_row    = 1'b0;

      case (state_ff)
         tcw_pkg::ST_IDLE: begin
            if (accept) begin
               case (req_mode)
                  tcw_pkg::MODE_PUT: begin
                     if (req_char_code == tcw_pkg::NEWLINE_CODE) begin
                        advance_row = 1'b1;
                     end else if (req_char_code != tcw_pkg::NULL_CODE) begin
                        ram_we    = 1'b1;
                        ram_waddr = cursor_addr;
                        ram_wdata = '{color: req_char_color, code: req_char_code};
                        if (col_ff == tcw_pkg::LAST_COL) begin
                           advance_row = 1'b1;
                        end else begin
                           col_in = col_ff + 1'b1;
                        end
                     end
                     if (advance_row) begin
                        col_in = '0;
                        if (base_adv == tcw_pkg::CELLS_S) begin
                           // Ran past the bottom row: move every row up by one.
                           state_in  = tcw_pkg::ST_SCROLL;
                           ptr_in    = tcw_pkg::COLS_A;
                           pend_in   = 1'b0;
                           rsp_en_in = 1'b1;
                        end else begin
                           base_in      = base_adv[tcw_pkg::ADDR_W-1:0];
                           rsp_valid_in = 1'b1;
                        end
                     end else begin
                        rsp_valid_in = 1'b1;
                     end
                  end
                  tcw_pkg::MODE_CLEAR_SCREEN: begin
                     base_in        = '0;
                     col_in         = '0;
                     ptr_in         = '0;
                     end_in         = tcw_pkg::LAST_A;
                     blank_color_in = fill_color_ff;
                     rsp_en_in      = 1'b1;
                     state_in       = tcw_pkg::ST_BLANK;
                  end
                  tcw_pkg::MODE_CLEAR_LINE: begin
                     col_in         = '0;
                     ptr_in         = base_ff;
                     end_in         = base_ff + tcw_pkg::COLS_A - 1'b1;
                     blank_color_in = fill_color_ff;
                     rsp_en_in      = 1'b1;
                     state_in       = tcw_pkg::ST_BLANK;
                  end
                  default: begin
                     // Cell read: out-of-range indexes answer zero at once.
                     if (idx_wide < tcw_pkg::CELLS_W) begin
                        ram_raddr = idx_wide[tcw_pkg::ADDR_W-1:0];
                        state_in  = tcw_pkg::ST_READ;
                     end else begin
                        rsp_valid_in = 1'b1;
                     end
                  end
               endcase
            end
         end
         tcw_pkg::ST_READ: begin
            rsp_valid_in = 1'b1;
            rsp_char_in  = ram_rdata.code;
            rsp_color_in = ram_rdata.color;
            state_in     = tcw_pkg::ST_IDLE;
         end
         tcw_pkg::ST_SCROLL: begin
            // Read one row below, write the cell read in the previous cycle.
            ram_raddr  = ptr_ff;
            ram_we     = pend_ff;
            ram_waddr  = wr_addr_ff;
            ram_wdata  = ram_rdata;
            pend_in    = 1'b1;
            wr_addr_in = ptr_ff - tcw_pkg::COLS_A;
            if (ptr_ff == tcw_pkg::LAST_A) begin
               state_in = tcw_pkg::ST_DRAIN;
            end else begin
               ptr_in = ptr_ff + 1'b1;
            end
         end
         tcw_pkg::ST_DRAIN: begin
            // Last moved cell, then blank the bottom row.
            ram_we         = 1'b1;
            ram_waddr      = wr_addr_ff;
            ram_wdata      = ram_rdata;
            pend_in        = 1'b0;
            ptr_in         = tcw_pkg::LAST_ROW_A;
            end_in         = tcw_pkg::LAST_A;
            blank_color_in = fill_color_ff;
            state_in       = tcw_pkg::ST_BLANK;
         end
         tcw_pkg::ST_BLANK: begin
            ram_we = 1'b1;
            if (ptr_ff == end_ff) begin
               state_in     = tcw_pkg::ST_IDLE;
               rsp_valid_in = rsp_en_ff;
               rsp_en_in    = 1'b0;
            end else begin
               ptr_in = ptr_ff + 1'b1;
            end
         end
         default: begin
            state_in = tcw_pkg::ST_IDLE;
         end
      endcase

      rsp_loc_in = loc_wide[tcw_pkg::LOC_W-1:0];
   end

   // Control registers; reset starts the clearing pass over the whole memory.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= tcw_pkg::ST_BLANK;
         fill_color_ff  <= tcw_pkg::FILL_RESET;
         base_ff        <= '0;
         col_ff         <= '0;
         ptr_ff         <= '0;
         end_ff         <= tcw_pkg::LAST_A;
         pend_ff        <= 1'b0;
         blank_color_ff <= tcw_pkg::FILL_RESET;
         rsp_en_ff      <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         base_ff        <= base_in;
         col_ff         <= col_in;
         ptr_ff         <= ptr_in;
         end_ff         <= end_in;
         pend_ff        <= pend_in;
         blank_color_ff <= blank_color_in;
         rsp_en_ff      <= rsp_en_in;
         rsp_valid_ff   <= rsp_valid_in;
         if (csr_wr_en) begin
            fill_color_ff <= csr_wr_data;
         end
      end
   end

   // Response payload and scroll write address.
   always_ff @(posedge clock) begin
      rsp_loc_ff   <= rsp_loc_in;
      rsp_char_ff  <= rsp_char_in;
      rsp_color_ff <= rsp_color_in;
      wr_addr_ff   <= wr_addr_in;
   end

   assign busy                = (state_ff != tcw_pkg::ST_IDLE);
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_cursor_location = rsp_loc_ff;
   assign rsp_read_char       = rsp_char_ff;
   assign rsp_read_color      = rsp_color_ff;

   // A response beat only appears once the sequencer is back at rest.
   `TCW_ASSERT_NOW(a_rsp_when_idle, rsp_valid, !busy)
   // The cursor never leaves the screen.
   `TCW_ASSERT_NOW(a_cursor_on_screen, 1'b1,
      (tcw_pkg::SPAN_W'(base_ff) + tcw_pkg::SPAN_W'(col_ff)) < tcw_pkg::CELLS_S)
   // Every request beat either answers next cycle or keeps the block busy.
   `TCW_ASSERT_NEXT(a_accept_progress, start && !busy, rsp_valid || busy)
   // A scroll write always lands at a lower address than the cell being read.
   `TCW_ASSERT_NOW(a_scroll_order, (state_ff == tcw_pkg::ST_SCROLL) && pend_ff,
      wr_addr_ff < ptr_ff)

endmodule
